// ===== rtl/cai_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular arc interpolator package
// Shared constants, configuration register indexes, pipeline side-band
// structures and the CORDIC step functions.
// ----------------------------------------------------------------------------
package cai_pkg;

  localparam int CORDIC_STAGES = 24;
  // CORDIC datapath width: Q16.16 with 16 guard bits plus headroom for the gain.
  localparam int CW            = 52;
  // Numerator width of the step-angle division.
  localparam int DIV_BITS      = 61;

  localparam logic [31:0] ANG_QUARTER     = 32'h4000_0000;
  localparam logic [31:0] ANG_NEG_QUARTER = 32'hC000_0000;
  localparam logic [29:0] RAD_TO_BANG     = 30'd683565276;
  localparam logic [31:0] TWO_PI_Q29      = 32'd3373259426;
  localparam logic [29:0] KINV_Q30        = 30'd652032875;

  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_RADIUS    = 3'd2,
    REG_CLOCKWISE = 3'd3,
    REG_START_X   = 3'd4,
    REG_START_Y   = 3'd5,
    REG_END_X     = 3'd6,
    REG_END_Y     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic               func;
    logic signed [32:0] dxa;
    logic signed [32:0] dya;
    logic signed [32:0] dxb;
    logic signed [32:0] dyb;
  } div_side_t;

  typedef struct packed {
    logic        func;
    logic [31:0] theta;
    logic        cross_lt;
  } vec_side_t;

  typedef struct packed {
    logic        func;
    logic [32:0] sweep;
  } rot_side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
  } cordic_t;

  // atan(2^-i) in binary angle units, one turn being 2^32.
  function automatic logic [31:0] atan_at(input int unsigned i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      28: a = 32'd3;
      29: a = 32'd1;
      30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // One vectoring step: drive y towards zero.
  function automatic cordic_t vec_iter(input cordic_t c, input int unsigned sh);
    cordic_t              r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = $signed(c.x) >>> sh;
    ys = $signed(c.y) >>> sh;
    if (c.y[CW-1]) begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - atan_at(sh);
    end else begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + atan_at(sh);
    end
    return r;
  endfunction

  // One rotation step: drive the residual angle towards zero.
  function automatic cordic_t rot_iter(input cordic_t c, input int unsigned sh);
    cordic_t              r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = $signed(c.x) >>> sh;
    ys = $signed(c.y) >>> sh;
    if (!c.z[31]) begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - atan_at(sh);
    end else begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + atan_at(sh);
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/cai_div.sv =====
// ----------------------------------------------------------------------------
// Step-angle divider
// Computes round(step_len * RAD_TO_BANG / radius) modulo one turn with a
// restoring divider, one quotient bit per stage, carrying the item along.
// ----------------------------------------------------------------------------
module cai_div import cai_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [30:0] step,
  input  logic [30:0] radius,
  input  div_side_t   in_side,
  output logic        out_vld,
  output logic [31:0] theta,
  output div_side_t   out_side
);

  logic                vld_m_r;
  logic [DIV_BITS-1:0] prod_m_r;
  div_side_t           side_m_r;

  logic [DIV_BITS:0]   vld_r;
  logic [DIV_BITS-1:0] num_r  [0:DIV_BITS];
  logic [30:0]         rem_r  [0:DIV_BITS];
  logic [31:0]         quo_r  [0:DIV_BITS];
  div_side_t           side_r [0:DIV_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m_r <= 1'b0;
      vld_r   <= '0;
    end else if (en) begin
      vld_m_r <= in_vld;
      vld_r   <= {vld_r[DIV_BITS-1:0], vld_m_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_m_r  <= DIV_BITS'(step) * DIV_BITS'(RAD_TO_BANG);
      side_m_r  <= in_side;
      // Adding half the divisor turns the truncating division into rounding.
      num_r[0]  <= prod_m_r + DIV_BITS'(radius[30:1]);
      rem_r[0]  <= '0;
      quo_r[0]  <= '0;
      side_r[0] <= side_m_r;
      for (int k = 0; k < DIV_BITS; k++) begin
        logic [31:0] t;
        logic        ge;
        t  = {rem_r[k], num_r[k][DIV_BITS-1]};
        ge = (t >= {1'b0, radius});
        rem_r[k+1]  <= ge ? 31'(t - {1'b0, radius}) : t[30:0];
        quo_r[k+1]  <= {quo_r[k][30:0], ge};
        num_r[k+1]  <= {num_r[k][DIV_BITS-2:0], 1'b0};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_vld  = vld_r[DIV_BITS];
  assign theta    = (radius == '0) ? 32'd0 : quo_r[DIV_BITS];
  assign out_side = side_r[DIV_BITS];

endmodule

// ===== rtl/cai_vec.sv =====
// ----------------------------------------------------------------------------
// Dual-lane vectoring CORDIC
// Finds the binary angle of two centre-relative vectors side by side, one
// micro-rotation per stage.
// ----------------------------------------------------------------------------
module cai_vec import cai_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [32:0] ax,
  input  logic signed [32:0] ay,
  input  logic signed [32:0] bx,
  input  logic signed [32:0] by,
  input  vec_side_t          in_side,
  output logic               out_vld,
  output logic [31:0]        ang_a,
  output logic [31:0]        ang_b,
  output vec_side_t          out_side
);

  function automatic cordic_t prerot(input logic signed [32:0] dx,
                                     input logic signed [32:0] dy);
    cordic_t              r;
    logic signed [CW-1:0] xw;
    logic signed [CW-1:0] yw;
    xw = CW'(dx);
    yw = CW'(dy);
    xw = xw <<< 16;
    yw = yw <<< 16;
    // Fold the left half-plane into the right one by a quarter turn.
    if (xw[CW-1]) begin
      if (!yw[CW-1]) begin
        r.x = yw;
        r.y = -xw;
        r.z = ANG_QUARTER;
      end else begin
        r.x = -yw;
        r.y = xw;
        r.z = ANG_NEG_QUARTER;
      end
    end else begin
      r.x = xw;
      r.y = yw;
      r.z = '0;
    end
    return r;
  endfunction

  logic [CORDIC_STAGES:0] vld_r;
  logic [CORDIC_STAGES:0] za_r;
  logic [CORDIC_STAGES:0] zb_r;
  cordic_t                ca_r   [0:CORDIC_STAGES];
  cordic_t                cb_r   [0:CORDIC_STAGES];
  vec_side_t              side_r [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[CORDIC_STAGES-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca_r[0]   <= prerot(ax, ay);
      cb_r[0]   <= prerot(bx, by);
      za_r      <= {za_r[CORDIC_STAGES-1:0], (ax == '0) && (ay == '0)};
      zb_r      <= {zb_r[CORDIC_STAGES-1:0], (bx == '0) && (by == '0)};
      side_r[0] <= in_side;
      for (int k = 0; k < CORDIC_STAGES; k++) begin
        ca_r[k+1]   <= vec_iter(ca_r[k], k);
        cb_r[k+1]   <= vec_iter(cb_r[k], k);
        side_r[k+1] <= side_r[k];
      end
    end
  end

  // A zero vector has angle zero.
  assign out_vld  = vld_r[CORDIC_STAGES];
  assign ang_a    = za_r[CORDIC_STAGES] ? 32'd0 : ca_r[CORDIC_STAGES].z;
  assign ang_b    = zb_r[CORDIC_STAGES] ? 32'd0 : cb_r[CORDIC_STAGES].z;
  assign out_side = side_r[CORDIC_STAGES];

endmodule

// ===== rtl/cai_rot.sv =====
// ----------------------------------------------------------------------------
// Rotation CORDIC and sweep select
// Moves the current angle by the step angle and rotates (r, 0) to it; for
// arc-length requests it works out the swept angle from start to end.
// ----------------------------------------------------------------------------
module cai_rot import cai_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [31:0]          ang_a,
  input  logic [31:0]          ang_b,
  input  vec_side_t            in_side,
  input  logic                 clockwise,
  input  logic [30:0]          radius,
  output logic                 out_vld,
  output logic signed [CW-1:0] ox,
  output logic signed [CW-1:0] oy,
  output rot_side_t            out_side
);

  logic        vld0_r;
  logic [31:0] z0_r;
  logic [60:0] x0p_r;
  rot_side_t   side0_r;

  logic [31:0] ang_new;
  logic [31:0] diff;
  logic [31:0] diff_neg;
  logic [31:0] shrt;
  logic [32:0] full;
  rot_side_t   side0_nxt;
  cordic_t     pre_nxt;

  always_comb begin
    ang_new  = clockwise ? (ang_a - in_side.theta) : (ang_a + in_side.theta);
    diff     = ang_a - ang_b;
    diff_neg = 32'd0 - diff;
    shrt     = (diff_neg < diff) ? diff_neg : diff;
    full     = 33'h1_0000_0000 - 33'(shrt);
    side0_nxt.func = in_side.func;
    // The cross-product sign tells whether the short way runs clockwise.
    if (in_side.cross_lt) begin
      side0_nxt.sweep = clockwise ? 33'(shrt) : full;
    end else begin
      side0_nxt.sweep = clockwise ? full : 33'(shrt);
    end
  end

  always_comb begin
    logic signed [CW-1:0] x0;
    x0 = CW'(x0p_r >> 14);
    if ($signed(z0_r) > $signed(ANG_QUARTER)) begin
      pre_nxt.x = '0;
      pre_nxt.y = x0;
      pre_nxt.z = z0_r - ANG_QUARTER;
    end else if ($signed(z0_r) < $signed(ANG_NEG_QUARTER)) begin
      pre_nxt.x = '0;
      pre_nxt.y = -x0;
      pre_nxt.z = z0_r + ANG_QUARTER;
    end else begin
      pre_nxt.x = x0;
      pre_nxt.y = '0;
      pre_nxt.z = z0_r;
    end
  end

  logic [CORDIC_STAGES:0] vld_r;
  cordic_t                c_r    [0:CORDIC_STAGES];
  rot_side_t              side_r [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld_r  <= '0;
    end else if (en) begin
      vld0_r <= in_vld;
      vld_r  <= {vld_r[CORDIC_STAGES-1:0], vld0_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z0_r      <= ang_new;
      x0p_r     <= 61'(radius) * 61'(KINV_Q30);
      side0_r   <= side0_nxt;
      c_r[0]    <= pre_nxt;
      side_r[0] <= side0_r;
      for (int k = 0; k < CORDIC_STAGES; k++) begin
        c_r[k+1]    <= rot_iter(c_r[k], k);
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_vld  = vld_r[CORDIC_STAGES];
  assign ox       = c_r[CORDIC_STAGES].x;
  assign oy       = c_r[CORDIC_STAGES].y;
  assign out_side = side_r[CORDIC_STAGES];

endmodule

// ===== rtl/circular_arc_interpolator.sv =====
// ----------------------------------------------------------------------------
// Circular arc interpolator
// Next point along an arc, or the arc length from start to end, in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   The arc is set through the cfg_ write channel (centre, radius, direction,
//   start and end point, by register index); cfg_ready is always high and
//   registers are to be written only while no request is in flight.
//   Each input request carries in_func: 0 asks for the next point from
//   in_cur_x/in_cur_y advanced by in_step_len, 1 asks for the arc length.
//   Every request gives exactly one result; out_kind echoes in_func and the
//   fields not asked for read zero.
//   Throughput is one request per cycle while no result is stalled. A request
//   passes in order through the one-bit-per-stage step-angle divider, the
//   cross product stage, the vectoring CORDIC, the rotation CORDIC and the
//   output arithmetic.
//   The whole pipeline advances together: while out_valid is high and
//   out_ready low, every stage holds and in_ready is low; nothing is lost.
//   Reset clears all valid bits and restores the configuration defaults.
// ----------------------------------------------------------------------------
module circular_arc_interpolator import cai_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic signed [31:0] in_cur_x,
  input  logic signed [31:0] in_cur_y,
  input  logic [30:0]        in_step_len,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_next_x,
  output logic signed [31:0] out_next_y,
  output logic [31:0]        out_arc_length,
  output logic               out_kind,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic signed [31:0] center_x_r;
  logic signed [31:0] center_y_r;
  logic [30:0]        radius_r;
  logic               clockwise_r;
  logic signed [31:0] start_x_r;
  logic signed [31:0] start_y_r;
  logic signed [31:0] end_x_r;
  logic signed [31:0] end_y_r;

  logic en;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= '0;
      center_y_r  <= '0;
      radius_r    <= 31'd65536;
      clockwise_r <= 1'b0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      end_x_r     <= '0;
      end_y_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:  center_x_r  <= cfg_data;
        REG_CENTER_Y:  center_y_r  <= cfg_data;
        REG_RADIUS:    radius_r    <= cfg_data[30:0];
        REG_CLOCKWISE: clockwise_r <= cfg_data[0];
        REG_START_X:   start_x_r   <= cfg_data;
        REG_START_Y:   start_y_r   <= cfg_data;
        REG_END_X:     end_x_r     <= cfg_data;
        REG_END_Y:     end_y_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Lane A sees the current point for a next-point request and the end point
  // for an arc-length request; lane B always sees the start point.
  div_side_t in_side;

  always_comb begin
    in_side.func = in_func;
    if (in_func) begin
      in_side.dxa = 33'(end_x_r) - 33'(center_x_r);
      in_side.dya = 33'(end_y_r) - 33'(center_y_r);
    end else begin
      in_side.dxa = 33'(in_cur_x) - 33'(center_x_r);
      in_side.dya = 33'(in_cur_y) - 33'(center_y_r);
    end
    in_side.dxb = 33'(start_x_r) - 33'(center_x_r);
    in_side.dyb = 33'(start_y_r) - 33'(center_y_r);
  end

  logic        div_vld;
  logic [31:0] div_theta;
  div_side_t   div_side;

  cai_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .step     (in_step_len),
    .radius   (radius_r),
    .in_side  (in_side),
    .out_vld  (div_vld),
    .theta    (div_theta),
    .out_side (div_side)
  );

  // Cross product stage.
  logic               x1_vld_r;
  logic               x1_func_r;
  logic [31:0]        x1_theta_r;
  logic signed [32:0] x1_dxa_r;
  logic signed [32:0] x1_dya_r;
  logic signed [32:0] x1_dxb_r;
  logic signed [32:0] x1_dyb_r;
  logic signed [65:0] x1_pa_r;
  logic signed [65:0] x1_pb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_vld_r <= 1'b0;
    end else if (en) begin
      x1_vld_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_func_r  <= div_side.func;
      x1_theta_r <= div_theta;
      x1_dxa_r   <= div_side.dxa;
      x1_dya_r   <= div_side.dya;
      x1_dxb_r   <= div_side.dxb;
      x1_dyb_r   <= div_side.dyb;
      x1_pa_r    <= div_side.dya * div_side.dxb;
      x1_pb_r    <= div_side.dxa * div_side.dyb;
    end
  end

  vec_side_t vec_in_side;

  always_comb begin
    vec_in_side.func     = x1_func_r;
    vec_in_side.theta    = x1_theta_r;
    vec_in_side.cross_lt = (x1_pa_r < x1_pb_r);
  end

  logic        vec_vld;
  logic [31:0] vec_ang_a;
  logic [31:0] vec_ang_b;
  vec_side_t   vec_side;

  cai_vec u_vec (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (x1_vld_r),
    .ax       (x1_dxa_r),
    .ay       (x1_dya_r),
    .bx       (x1_dxb_r),
    .by       (x1_dyb_r),
    .in_side  (vec_in_side),
    .out_vld  (vec_vld),
    .ang_a    (vec_ang_a),
    .ang_b    (vec_ang_b),
    .out_side (vec_side)
  );

  logic                 rot_vld;
  logic signed [CW-1:0] rot_ox;
  logic signed [CW-1:0] rot_oy;
  rot_side_t            rot_side;

  cai_rot u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (vec_vld),
    .ang_a     (vec_ang_a),
    .ang_b     (vec_ang_b),
    .in_side   (vec_side),
    .clockwise (clockwise_r),
    .radius    (radius_r),
    .out_vld   (rot_vld),
    .ox        (rot_ox),
    .oy        (rot_oy),
    .out_side  (rot_side)
  );

  // Post stage 1: point rounding and the radius times sweep product.
  logic                 rx_sh;
  logic signed [CW-1:0] rx_rnd;
  logic signed [CW-1:0] ry_rnd;
  logic signed [39:0]   px_sum;
  logic signed [39:0]   py_sum;

  assign rx_sh  = 1'b0;
  assign rx_rnd = (rot_ox + CW'(32'sd32768)) >>> 16;
  assign ry_rnd = (rot_oy + CW'(32'sd32768)) >>> 16;
  assign px_sum = 40'(center_x_r) + 40'(rx_rnd);
  assign py_sum = 40'(center_y_r) + 40'(ry_rnd);

  logic        p1_vld_r;
  logic        p1_func_r;
  logic [31:0] p1_x_r;
  logic [31:0] p1_y_r;
  logic [63:0] p1_q_r;

  logic        p2_vld_r;
  logic        p2_func_r;
  logic [31:0] p2_x_r;
  logic [31:0] p2_y_r;
  logic [63:0] p2_hi_r;
  logic [63:0] p2_lo_r;

  logic [63:0] len_sum;
  logic [63:0] len_rnd;

  assign len_sum = p2_hi_r + {32'd0, p2_lo_r[63:32]};
  assign len_rnd = (len_sum + 64'h1000_0000) >> 29;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p1_vld_r  <= rot_vld;
      p2_vld_r  <= p1_vld_r;
      out_valid <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_func_r <= rot_side.func ^ rx_sh;
      p1_x_r    <= sat32(px_sum);
      p1_y_r    <= sat32(py_sum);
      p1_q_r    <= 64'(radius_r) * 64'(rot_side.sweep);

      p2_func_r <= p1_func_r;
      p2_x_r    <= p1_x_r;
      p2_y_r    <= p1_y_r;
      p2_hi_r   <= 64'(p1_q_r[63:32]) * 64'(TWO_PI_Q29);
      p2_lo_r   <= 64'(p1_q_r[31:0]) * 64'(TWO_PI_Q29);

      out_kind       <= p2_func_r;
      out_next_x     <= p2_func_r ? 32'sd0 : p2_x_r;
      out_next_y     <= p2_func_r ? 32'sd0 : p2_y_r;
      if (!p2_func_r) begin
        out_arc_length <= 32'd0;
      end else if (len_rnd > 64'hFFFF_FFFF) begin
        out_arc_length <= 32'hFFFF_FFFF;
      end else begin
        out_arc_length <= len_rnd[31:0];
      end
    end
  end

endmodule

// ===== rtl/cai_checker.sv =====
// ----------------------------------------------------------------------------
// Circular arc interpolator port checker
// Watches the top-level ports for stall holding, handshakes and field consistency.
// ----------------------------------------------------------------------------
module cai_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_func,
  input logic [31:0] in_cur_x,
  input logic [31:0] in_cur_y,
  input logic [30:0] in_step_len,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_next_x,
  input logic [31:0] out_next_y,
  input logic [31:0] out_arc_length,
  input logic        out_kind,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [31:0] cfg_data
);

  // A stalled result must hold completely.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_x) &&
      $stable(out_next_y) && $stable(out_arc_length) && $stable(out_kind))
    else $error("result changed while stalled");

  // The pipeline only refuses new requests while a result is blocked.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input refused with no stalled result");

  a_point_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> out_arc_length == 32'd0)
    else $error("arc length set on a next-point result");

  a_arc_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_next_x == 32'd0 && out_next_y == 32'd0)
    else $error("point set on an arc-length result");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind circular_arc_interpolator cai_checker u_cai_checker (.*);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Circular arc interpolator testbench
// Walks a directed table of arc settings and requests, then random arcs with
// random next-point and arc-length requests. Every result is compared against
// a bit-exact CORDIC predictor, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
  import cai_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 130;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_func = 1'b0;
  logic signed [31:0] in_cur_x = '0;
  logic signed [31:0] in_cur_y = '0;
  logic [30:0]        in_step_len = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_next_x;
  logic signed [31:0] out_next_y;
  logic [31:0]        out_arc_length;
  logic               out_kind;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  circular_arc_interpolator u_top (.*);

  always #5 clk = ~clk;

  typedef struct {
    logic        kind;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] len;
  } arc_result_t;

  typedef struct {
    bit          is_cfg;
    cfg_reg_t    idx;
    logic [31:0] data;
    logic        func;
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] step;
    bit          typed;
    logic [31:0] typed_len;
  } row_t;

  arc_result_t pending[$];
  int          n_errors = 0;
  int          n_results = 0;
  int          n_points = 0;
  int          n_lengths = 0;

  // Local copy of the arc registers.
  longint          ctr_x, ctr_y, beg_x, beg_y, fin_x, fin_y;
  longint unsigned rad;
  bit              cw;

  function automatic logic [31:0] angle_of(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    z = 0;
    if (dx == 0 && dy == 0) return '0;
    x = dx * 65536;
    y = dy * 65536;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 1073741824;
      end else begin
        x = -y; y = t; z = -1073741824;
      end
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x -= ys; y += xs; z -= longint'(atan_at(i));
      end else begin
        x += ys; y -= xs; z += longint'(atan_at(i));
      end
    end
    return z[31:0];
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit cross_less(longint a, longint b, longint c, longint d);
    logic signed [67:0] ea, eb, ec, ed;
    ea = a; eb = b; ec = c; ed = d;
    return (ea * eb) < (ec * ed);
  endfunction

  function automatic arc_result_t predict_arc(logic func, logic [31:0] px, logic [31:0] py,
                                              logic [30:0] step);
    arc_result_t     r;
    longint          x, y, z, xs, ys;
    longint unsigned num, sweep, shrt, q, len;
    logic [31:0]     th, a, d;
    r.kind = func; r.nx = '0; r.ny = '0; r.len = '0;
    if (!func) begin
      num = longint'(step) * 64'd683565276 + (rad >> 1);
      // A zero radius gives no step at all.
      th = (rad == 0) ? 32'd0 : 32'(num / rad);
      a = angle_of(longint'($signed(px)) - ctr_x, longint'($signed(py)) - ctr_y);
      a = cw ? a - th : a + th;
      x = (longint'(rad) * 64'sd652032875) >>> 14;
      y = 0;
      z = longint'($signed(a));
      if (z > 1073741824) begin
        y = x; x = 0; z -= 1073741824;
      end else if (z < -1073741824) begin
        y = -x; x = 0; z += 1073741824;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= longint'(atan_at(i));
        end else begin
          x += ys; y -= xs; z += longint'(atan_at(i));
        end
      end
      r.nx = 32'(clamp32(ctr_x + ((x + 32768) >>> 16)));
      r.ny = 32'(clamp32(ctr_y + ((y + 32768) >>> 16)));
    end else begin
      d = angle_of(fin_x - ctr_x, fin_y - ctr_y) - angle_of(beg_x - ctr_x, beg_y - ctr_y);
      shrt = d;
      if (longint'(32'(-d)) < shrt) shrt = 32'(-d);
      if (cross_less(fin_y - ctr_y, beg_x - ctr_x, fin_x - ctr_x, beg_y - ctr_y))
        sweep = cw ? shrt : 64'h1_0000_0000 - shrt;
      else
        sweep = cw ? 64'h1_0000_0000 - shrt : shrt;
      q = rad * sweep;
      len = (q >> 32) * longint'(TWO_PI_Q29) +
            (((q & 64'hFFFF_FFFF) * longint'(TWO_PI_Q29)) >> 32);
      len = (len + (64'd1 << 28)) >> 29;
      r.len = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("MISMATCH %s at %0t: got %h, expected %h", what, $realtime, got, want);
  endtask

  always @(posedge clk) begin
    arc_result_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending.size() == 0) begin
        report("unexpected result", out_kind, 1'b0);
      end else begin
        e = pending.pop_front();
        if (out_kind !== e.kind) report("kind", out_kind, e.kind);
        if (out_next_x !== e.nx) report("next_x", out_next_x, e.nx);
        if (out_next_y !== e.ny) report("next_y", out_next_y, e.ny);
        if (out_arc_length !== e.len) report("arc_length", out_arc_length, e.len);
      end
    end
  end

  // Receiver: free-running stretches, random stalls and a regular stall beat.
  int unsigned rx_cycle = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 700) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) > 3);
      default: out_ready <= (rx_cycle % 5 != 0);
    endcase
  end

  task automatic apply_reg(cfg_reg_t idx, logic [31:0] v);
    case (idx)
      REG_CENTER_X:  ctr_x = longint'($signed(v));
      REG_CENTER_Y:  ctr_y = longint'($signed(v));
      REG_RADIUS:    rad = v[30:0];
      REG_CLOCKWISE: cw = v[0];
      REG_START_X:   beg_x = longint'($signed(v));
      REG_START_Y:   beg_y = longint'($signed(v));
      REG_END_X:     fin_x = longint'($signed(v));
      default:       fin_y = longint'($signed(v));
    endcase
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Writes a full arc setting back to back; valid is lowered only at the end.
  task automatic write_arc(logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= v[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_reg(cfg_reg_t'(i), v[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  int burst_left = 0;

  task automatic send(logic func, logic [31:0] x, logic [31:0] y, logic [30:0] step,
                      bit typed, logic [31:0] typed_len);
    arc_result_t e;
    int          gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_func     <= func;
    in_cur_x    <= x;
    in_cur_y    <= y;
    in_step_len <= step;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e = predict_arc(func, x, y, step);
    if (typed && e.len !== typed_len) report("table arc_length", e.len, typed_len);
    if (typed) e.len = typed_len;
    pending.push_back(e);
    if (func) n_lengths++;
    else n_points++;
  endtask

  function automatic row_t reg_row(cfg_reg_t idx, logic [31:0] v);
    row_t r;
    r = '{1'b1, idx, v, 1'b0, '0, '0, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t req_row(logic f, logic [31:0] x, logic [31:0] y, logic [30:0] s,
                                   bit typed = 1'b0, logic [31:0] l = '0);
    row_t r;
    r = '{1'b0, REG_CENTER_X, '0, f, x, y, s, typed, l};
    return r;
  endfunction

  row_t directed[$];

  initial begin
    logic [31:0] arc[8];
    logic [31:0] px, py;
    ctr_x = 0; ctr_y = 0; beg_x = 0; beg_y = 0; fin_x = 0; fin_y = 0;
    rad = 65536; cw = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset all points sit on the centre, so the arc length is zero.
    directed = '{
      req_row(1'b1, 32'h0, 32'h0, 31'h0, 1'b1, 32'h0),
      req_row(1'b0, 32'h0, 32'h0, 31'h0),
      req_row(1'b0, 32'h0001_0000, 32'h0, 31'h0000_8000),
      req_row(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF),
      req_row(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0000_0001),
      reg_row(REG_START_X, 32'h0001_0000),
      reg_row(REG_END_X, 32'h0001_0000),
      req_row(1'b1, 32'h0, 32'h0, 31'h0, 1'b1, 32'h0),
      reg_row(REG_CLOCKWISE, 32'h1),
      req_row(1'b1, 32'h0, 32'h0, 31'h0),
      req_row(1'b0, 32'h0000_0000, 32'hFFFF_0000, 31'h0001_921F),
      reg_row(REG_END_X, 32'hFFFF_0000),
      req_row(1'b1, 32'h0, 32'h0, 31'h0),
      reg_row(REG_CLOCKWISE, 32'h0),
      req_row(1'b1, 32'h0, 32'h0, 31'h0),
      reg_row(REG_RADIUS, 32'h7FFF_FFFF),
      reg_row(REG_CENTER_X, 32'h7FFF_0000),
      reg_row(REG_CENTER_Y, 32'h8000_0000),
      req_row(1'b0, 32'h0, 32'h0, 31'h7FFF_FFFF),
      req_row(1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 31'h1234_5678),
      reg_row(REG_START_Y, 32'h8000_0000),
      reg_row(REG_END_Y, 32'h7FFF_FFFF),
      req_row(1'b1, 32'h0, 32'h0, 31'h0),
      reg_row(REG_RADIUS, 32'h1),
      req_row(1'b0, 32'h1234_5678, 32'h8765_4321, 31'h7FFF_FFFF),
      req_row(1'b1, 32'h0, 32'h0, 31'h0)
    };
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        in_valid  <= 1'b0;
        burst_left = 0;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= directed[i].idx;
        cfg_data  <= directed[i].data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        apply_reg(directed[i].idx, directed[i].data);
        cfg_valid <= 1'b0;
      end else begin
        send(directed[i].func, directed[i].x, directed[i].y, directed[i].step,
             directed[i].typed, directed[i].typed_len);
      end
    end

    // Random arcs: mostly moderate sizes, now and then full-range extremes.
    for (int ph = 0; ph < 9; ph++) begin
      in_valid  <= 1'b0;
      burst_left = 0;
      wait_idle();
      for (int i = 0; i < 8; i++) arc[i] = $urandom;
      if (ph % 3 != 2) begin
        arc[REG_CENTER_X] = $signed(arc[REG_CENTER_X]) >>> 8;
        arc[REG_CENTER_Y] = $signed(arc[REG_CENTER_Y]) >>> 8;
        arc[REG_RADIUS]   = $urandom_range(1, 32'h0100_0000);
        arc[REG_START_X]  = $signed(arc[REG_START_X]) >>> 8;
        arc[REG_START_Y]  = $signed(arc[REG_START_Y]) >>> 8;
        arc[REG_END_X]    = $signed(arc[REG_END_X]) >>> 8;
        arc[REG_END_Y]    = $signed(arc[REG_END_Y]) >>> 8;
      end
      arc[REG_CLOCKWISE] = {31'($urandom), ph[0]};
      write_arc(arc);
      @(posedge clk);
      for (int n = 0; n < 205; n++) begin
        px = $urandom;
        py = $urandom;
        if ($urandom_range(0, 3) != 0) begin
          // Points offset from the centre by a shifted random amount.
          px = 32'(ctr_x) + ($signed(px) >>> $urandom_range(4, 12));
          py = 32'(ctr_y) + ($signed(py) >>> $urandom_range(4, 12));
        end
        send($urandom_range(0, 4) == 0, px, py,
             ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h4_0000)),
             1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_idle();
    $display("Covered %0d next-point and %0d arc-length requests over 10 arc settings.",
             n_points, n_lengths);
    $display("%0d results compared, %0d mismatches.", n_results, n_errors);
    if (n_errors == 0 && pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("Timed out with %0d results outstanding.", pending.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
